// ===== rtl/id3fp_pkg.sv =====
// ----------------------------------------------------------------------------
// id3fp_pkg
// Types and constants shared by the ID3v2 frame stream parser modules.
// ----------------------------------------------------------------------------
package id3fp_pkg;

  localparam logic [27:0] POS_MAX   = 28'hFFF_FFFF;
  localparam logic [3:0]  HDR_BYTES = 4'd10;
  localparam logic [3:0]  ID_END    = 4'd4;
  localparam logic [3:0]  SIZE_END  = 4'd8;
  localparam logic [3:0]  SIZE_LAST = 4'd7;
  localparam logic [3:0]  FLAGS_HI  = 4'd8;
  localparam logic [3:0]  LEN_LAST  = 4'd3;
  localparam logic [7:0]  BYTE_FF   = 8'hFF;

  localparam logic [1:0] REG_VERSION = 2'd0;
  localparam logic [1:0] REG_UNSYNC  = 2'd1;
  localparam logic [1:0] REG_LENGTH  = 2'd2;

  localparam int FLAG_GROUP  = 4;
  localparam int FLAG_UNSYNC = 1;
  localparam int FLAG_DLEN   = 0;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_GROUP,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PAYLOAD   = 3'd1,
    KIND_FRAME_END = 3'd2,
    KIND_PADDING   = 3'd3,
    KIND_EXHAUSTED = 3'd4,
    KIND_ERROR     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SIZE_SS  = 2'd1,
    ERR_DLEN_SS  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] data_byte_in;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_id;
    logic [31:0] frame_size;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_group;
    logic [31:0] data_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
    err_t        error_code;
  } result_t;

  typedef struct packed {
    logic [2:0]  version;
    logic        unsync;
    logic [27:0] data_length;
  } cfg_t;

  function automatic logic not_synchsafe(input logic [31:0] v);
    return v[31] | v[23] | v[15] | v[7];
  endfunction

  function automatic logic [31:0] ss_unpack(input logic [31:0] v);
    return {4'd0, v[30:24], v[22:16], v[14:8], v[6:0]};
  endfunction

endpackage

// ===== rtl/id3fp_cfg.sv =====
// ----------------------------------------------------------------------------
// id3fp_cfg
// APB register file: tag version, tag unsync flag, tag frame-data length.
// ----------------------------------------------------------------------------
module id3fp_cfg import id3fp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.version     <= 3'd4;
      cfg.unsync      <= 1'b0;
      cfg.data_length <= 28'd0;
    end else if (wr) begin
      case (idx)
        REG_VERSION: cfg.version     <= pwdata[2:0];
        REG_UNSYNC:  cfg.unsync      <= pwdata[0];
        REG_LENGTH:  cfg.data_length <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VERSION: prdata = {29'd0, cfg.version};
      REG_UNSYNC:  prdata = {31'd0, cfg.unsync};
      REG_LENGTH:  prdata = {4'd0, cfg.data_length};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/id3fp_core.sv =====
// ----------------------------------------------------------------------------
// id3fp_core
// Input register and per-byte parse state; one byte processed per cycle unless held by the output skid stage.
// ----------------------------------------------------------------------------
module id3fp_core import id3fp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  input  logic    hold,
  output logic    res_valid,
  output result_t res
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic        take;

  phase_t      phase, phase_next, cur_phase;
  logic [27:0] position, position_next, cur_pos, pos_inc;
  logic [3:0]  fbc, fbc_next, cur_fbc;
  logic [31:0] id_shift, id_shift_next, cur_id, hid;
  logic [31:0] size_shift, size_shift_next, cur_size, hsize;
  logic [7:0]  flag_bits, flag_bits_next, cur_flags, hflags;
  logic [7:0]  group_reg, group_reg_next, cur_grp;
  logic [31:0] length_shift, length_shift_next, cur_len, hlen, new_len;
  logic [31:0] payload_left, payload_left_next, cur_left, left_dec;
  logic        prev_ff, prev_ff_next, cur_prev;

  logic        v4, no_room, overflow, do_finish, drop, last;
  logic        emit, eframe, elast;
  kind_t       ekind;
  err_t        eerr;
  logic [7:0]  ebyte;

  assign take       = s1_valid & ~hold;
  assign item_ready = ~s1_valid | take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      s1_byte  <= item.data_byte_in;
      s1_first <= item.first_byte;
    end
  end

  always_comb begin
    cur_phase = s1_first ? PH_HEADER : phase;
    cur_pos   = s1_first ? 28'd0 : position;
    cur_fbc   = s1_first ? 4'd0 : fbc;
    cur_id    = s1_first ? 32'd0 : id_shift;
    cur_size  = s1_first ? 32'd0 : size_shift;
    cur_flags = s1_first ? 8'd0 : flag_bits;
    cur_grp   = s1_first ? 8'd0 : group_reg;
    cur_len   = s1_first ? 32'd0 : length_shift;
    cur_left  = s1_first ? 32'd0 : payload_left;
    cur_prev  = s1_first ? 1'b0 : prev_ff;
  end

  assign v4       = cfg.version[2];
  assign pos_inc  = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 28'd1;
  assign no_room  = ({1'b0, cur_pos} + {25'd0, HDR_BYTES}) > {1'b0, cfg.data_length};
  assign overflow = ({5'd0, pos_inc} + {1'b0, cur_size}) > {5'd0, cfg.data_length};
  assign new_len  = {cur_len[23:0], s1_byte};
  assign left_dec = (cur_left != 32'd0) ? cur_left - 32'd1 : cur_left;
  assign last     = (left_dec == 32'd0);
  assign drop     = (cur_flags[FLAG_UNSYNC] | cfg.unsync) & cur_prev & (s1_byte == 8'd0);

  assign hid    = (cur_fbc == 4'd0) ? 32'd0 : cur_id;
  assign hsize  = (cur_fbc == 4'd0) ? 32'd0 : cur_size;
  assign hflags = (cur_fbc == 4'd0) ? 8'd0 : cur_flags;
  assign hlen   = (cur_fbc == 4'd0) ? 32'd0 : cur_len;

  // next state
  always_comb begin
    phase_next        = cur_phase;
    position_next     = cur_pos;
    fbc_next          = cur_fbc;
    id_shift_next     = cur_id;
    size_shift_next   = cur_size;
    flag_bits_next    = cur_flags;
    group_reg_next    = cur_grp;
    length_shift_next = cur_len;
    payload_left_next = cur_left;
    prev_ff_next      = cur_prev;
    emit      = 1'b0;
    ekind     = KIND_HEADER;
    eerr      = ERR_NONE;
    eframe    = 1'b0;
    elast     = 1'b0;
    ebyte     = 8'd0;
    do_finish = 1'b0;

    case (cur_phase)
      PH_HEADER: begin
        if (cur_fbc == 4'd0 && no_room) begin
          phase_next = PH_STOPPED;
          emit       = 1'b1;
          ekind      = KIND_EXHAUSTED;
        end else if (cur_fbc == 4'd0 && s1_byte == 8'd0) begin
          phase_next = PH_STOPPED;
          emit       = 1'b1;
          ekind      = KIND_PADDING;
        end else begin
          id_shift_next     = hid;
          size_shift_next   = hsize;
          flag_bits_next    = hflags;
          length_shift_next = hlen;
          if (cur_fbc == 4'd0) begin
            group_reg_next = 8'd0;
          end
          position_next = pos_inc;
          fbc_next      = cur_fbc + 4'd1;
          if (cur_fbc < ID_END) begin
            id_shift_next = {hid[23:0], s1_byte};
          end else if (cur_fbc < SIZE_END) begin
            size_shift_next = {hsize[23:0], s1_byte};
            if (cur_fbc == SIZE_LAST && v4) begin
              if (not_synchsafe({hsize[23:0], s1_byte})) begin
                phase_next = PH_STOPPED;
                emit       = 1'b1;
                ekind      = KIND_ERROR;
                eerr       = ERR_SIZE_SS;
              end else begin
                size_shift_next = ss_unpack({hsize[23:0], s1_byte});
              end
            end
          end else if (cur_fbc == FLAGS_HI) begin
            flag_bits_next = {s1_byte[6:4], 5'd0};
          end else begin
            flag_bits_next = hflags | {3'd0, s1_byte[6], s1_byte[3:0]};
            fbc_next       = 4'd0;
            if (flag_bits_next[FLAG_GROUP]) begin
              phase_next = PH_GROUP;
            end else if (flag_bits_next[FLAG_DLEN]) begin
              phase_next = PH_LENGTH;
            end else begin
              do_finish = 1'b1;
            end
          end
        end
      end
      PH_GROUP: begin
        position_next  = pos_inc;
        group_reg_next = s1_byte;
        if (cur_flags[FLAG_DLEN]) begin
          phase_next = PH_LENGTH;
          fbc_next   = 4'd0;
        end else begin
          do_finish = 1'b1;
        end
      end
      PH_LENGTH: begin
        position_next     = pos_inc;
        length_shift_next = new_len;
        fbc_next          = cur_fbc + 4'd1;
        if (cur_fbc == LEN_LAST) begin
          fbc_next = 4'd0;
          if (v4 && not_synchsafe(new_len)) begin
            phase_next = PH_STOPPED;
            emit       = 1'b1;
            ekind      = KIND_ERROR;
            eerr       = ERR_DLEN_SS;
          end else begin
            if (v4) begin
              length_shift_next = ss_unpack(new_len);
            end
            do_finish = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        position_next     = pos_inc;
        payload_left_next = left_dec;
        if (last) begin
          phase_next = PH_HEADER;
        end
        if (drop) begin
          prev_ff_next = 1'b0;
          if (last) begin
            emit   = 1'b1;
            ekind  = KIND_FRAME_END;
            eframe = 1'b1;
            elast  = 1'b1;
          end
        end else begin
          prev_ff_next = (s1_byte == BYTE_FF);
          emit   = 1'b1;
          ekind  = KIND_PAYLOAD;
          eframe = 1'b1;
          elast  = last;
          ebyte  = s1_byte;
        end
      end
      default: ;
    endcase

    if (do_finish) begin
      emit = 1'b1;
      if (overflow) begin
        phase_next = PH_STOPPED;
        ekind      = KIND_ERROR;
        eerr       = ERR_OVERFLOW;
      end else begin
        payload_left_next = cur_size;
        prev_ff_next      = 1'b0;
        fbc_next          = 4'd0;
        ekind             = KIND_HEADER;
        eframe            = 1'b1;
        if (cur_size == 32'd0) begin
          phase_next = PH_HEADER;
          elast      = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid        = take & emit;
    res.kind         = ekind;
    res.frame_id     = eframe ? id_shift_next : 32'd0;
    res.frame_size   = eframe ? size_shift_next : 32'd0;
    res.frame_flags  = eframe ? flag_bits_next : 8'd0;
    res.frame_group  = eframe ? group_reg_next : 8'd0;
    res.data_length  = eframe ? length_shift_next : 32'd0;
    res.payload_byte = ebyte;
    res.frame_last   = elast;
    res.error_code   = eerr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      position     <= 28'd0;
      fbc          <= 4'd0;
      id_shift     <= 32'd0;
      size_shift   <= 32'd0;
      flag_bits    <= 8'd0;
      group_reg    <= 8'd0;
      length_shift <= 32'd0;
      payload_left <= 32'd0;
      prev_ff      <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      position     <= position_next;
      fbc          <= fbc_next;
      id_shift     <= id_shift_next;
      size_shift   <= size_shift_next;
      flag_bits    <= flag_bits_next;
      group_reg    <= group_reg_next;
      length_shift <= length_shift_next;
      payload_left <= payload_left_next;
      prev_ff      <= prev_ff_next;
    end
  end

endmodule

// ===== rtl/id3fp_obuf.sv =====
// ----------------------------------------------------------------------------
// id3fp_obuf
// Result output register with a one-entry skid stage.
// ----------------------------------------------------------------------------
module id3fp_obuf import id3fp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    hold,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    skid_valid;
  result_t skid;

  assign hold = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (res_valid && !skid_valid) begin
        skid_valid <= 1'b1;
        skid       <= res;
      end
    end else if (skid_valid) begin
      result       <= skid;
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result_valid <= res_valid;
      if (res_valid) begin
        result <= res;
      end
    end
  end

endmodule

// ===== rtl/id3fp_top.sv =====
// ----------------------------------------------------------------------------
// id3v2_frame_stream_parser_top
// ID3v2 frame stream parser: frame headers, resynchronized payload bytes.
// ----------------------------------------------------------------------------
// Takes one frame-data byte per cycle with no gaps needed between bytes.
// Each byte is registered at the input, processed by the combinational
// parse-state update, and its result (if any) is registered in the output
// register or skid stage before it appears on the result port. The
// combinational state update sets the rate. A one-entry skid stage holds
// one more result while a result waits; input then stalls until it is taken.
// Registers (APB, byte address 0/4/8): tag version, tag unsync, tag length;
// write them only while the parser is idle.
module id3v2_frame_stream_parser_top import id3fp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  cfg_t    cfg;
  logic    hold;
  logic    res_valid;
  result_t res;

  id3fp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  id3fp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .hold       (hold),
    .res_valid  (res_valid),
    .res        (res)
  );

  id3fp_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res          (res),
    .hold         (hold),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold |-> result_valid)
    else $error("skid entry held with empty output register");

  a_no_new_when_held: assert property (@(posedge clk) disable iff (rst)
    hold |-> !res_valid)
    else $error("result produced while skid stage full");

  a_err_code_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  a_byte_only_payload: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_PAYLOAD) |-> (result.payload_byte == 8'd0))
    else $error("payload byte set on non-payload result");

endmodule
